// ===== sv/ubag_pkg.sv =====
// Shared constants, codes and controller/datapath types for the unordered bag.
`default_nettype none
package ubag_pkg;

   localparam int CAPACITY_DEFAULT    = 64;
   localparam int VALUE_WIDTH_DEFAULT = 32;

   localparam int CMD_W    = 2;
   localparam int ITEM_W   = 32;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 7;

   localparam logic [CMD_W-1:0] CMD_ADD        = 2'd0;
   localparam logic [CMD_W-1:0] CMD_REMOVE_ONE = 2'd1;
   localparam logic [CMD_W-1:0] CMD_REMOVE_ALL = 2'd2;

   localparam logic [STATUS_W-1:0] ST_DONE      = 2'd0;
   localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;

   typedef struct packed {
      logic                load;
      logic                add;
      logic                rd_last;
      logic                idx_inc;
      logic                move;
      logic                emit;
      logic [STATUS_W-1:0] status;
   } dp_cmd_type;

   typedef struct packed {
      logic idx_end;
      logic match;
      logic full;
      logic removed_zero;
      logic rsp_free;
   } dp_stat_type;

endpackage
`default_nettype wire

// ===== sv/ubag_ifs.sv =====
// Valid/ready channel interfaces for bag requests and responses.
`default_nettype none
interface ubag_req_if;
   logic                                valid;
   logic                                ready;
   logic        [ubag_pkg::CMD_W-1:0]  command;
   logic signed [ubag_pkg::ITEM_W-1:0] item_value;

   modport source (output valid, command, item_value, input ready);
   modport sink   (input valid, command, item_value, output ready);
endinterface

interface ubag_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [ubag_pkg::STATUS_W-1:0]   status;
   logic [ubag_pkg::COUNT_W-1:0]    removed_count;
   logic [ubag_pkg::COUNT_W-1:0]    entry_count;

   modport source (output valid, status, removed_count, entry_count, input ready);
   modport sink   (input valid, status, removed_count, entry_count, output ready);
endinterface
`default_nettype wire

// ===== sv/unordered_bag_swap_remove.sv =====
// Unordered bag top level: add, remove-first-match, remove-all with swap-with-last.
// Add: the item is written in S_ADD unless the bag is full; the response is registered
// from S_DONE once the response register is free. Remove: S_SCAN and S_CMP compare each
// entry in turn, and S_MOVE copies the last entry over each match that is removed.
// One item in flight; the next item is taken while the response waits.
// Synchronous reset empties the bag; entry memory is not cleared.
`default_nettype none
module unordered_bag_swap_remove #(
   parameter int CAPACITY    = ubag_pkg::CAPACITY_DEFAULT,
   parameter int VALUE_WIDTH = ubag_pkg::VALUE_WIDTH_DEFAULT
) (
   input wire logic   clock,
   input wire logic   reset,
   ubag_req_if.sink   req,
   ubag_rsp_if.source rsp
);

   ubag_pkg::dp_cmd_type  cmd;
   ubag_pkg::dp_stat_type stat;

   ubag_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req.valid),
      .req_ready   (req.ready),
      .req_command (req.command),
      .stat        (stat),
      .cmd         (cmd)
   );

   ubag_dp #(
      .CAPACITY    (CAPACITY),
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .req_item_value    (req.item_value),
      .rsp_ready         (rsp.ready),
      .rsp_valid         (rsp.valid),
      .rsp_status        (rsp.status),
      .rsp_removed_count (rsp.removed_count),
      .rsp_entry_count   (rsp.entry_count)
   );

endmodule
`default_nettype wire

// ===== sv/ubag_dp.sv =====
// Bag datapath: entry memory, fill count, scan index and response register.
`default_nettype none
module ubag_dp #(
   parameter int CAPACITY    = ubag_pkg::CAPACITY_DEFAULT,
   parameter int VALUE_WIDTH = ubag_pkg::VALUE_WIDTH_DEFAULT
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire ubag_pkg::dp_cmd_type                cmd,
   output      ubag_pkg::dp_stat_type               stat,
   input  wire logic signed [ubag_pkg::ITEM_W-1:0]  req_item_value,
   input  wire logic                                rsp_ready,
   output      logic                                rsp_valid,
   output      logic [ubag_pkg::STATUS_W-1:0]       rsp_status,
   output      logic [ubag_pkg::COUNT_W-1:0]        rsp_removed_count,
   output      logic [ubag_pkg::COUNT_W-1:0]        rsp_entry_count
);

   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

   logic [VALUE_WIDTH-1:0] entry_mem_ff [CAPACITY];
   logic [VALUE_WIDTH-1:0] rd_data_ff;
   logic [VALUE_WIDTH-1:0] value_ff, value_in;
   logic [CNT_W-1:0]       fill_ff, fill_in;
   logic [CNT_W-1:0]       idx_ff, idx_in;
   logic [CNT_W-1:0]       removed_ff, removed_in;
   logic [CNT_W-1:0]       last;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [ubag_pkg::STATUS_W-1:0] status_ff, status_in;
   logic [ubag_pkg::COUNT_W-1:0]  removed_out_ff, removed_out_in;
   logic [ubag_pkg::COUNT_W-1:0]  entry_out_ff, entry_out_in;
   logic                   wr_en;
   logic [IDX_W-1:0]       wr_addr;
   logic [VALUE_WIDTH-1:0] wr_data;
   logic [IDX_W-1:0]       rd_addr;

   assign last = fill_ff - CNT_W'(1);

   always_comb begin
      fill_in        = fill_ff;
      idx_in         = idx_ff;
      removed_in     = removed_ff;
      value_in       = value_ff;
      rsp_valid_in   = rsp_valid_ff;
      status_in      = status_ff;
      removed_out_in = removed_out_ff;
      entry_out_in   = entry_out_ff;
      if (cmd.load) begin
         idx_in     = '0;
         removed_in = '0;
         value_in   = VALUE_WIDTH'(64'(req_item_value));
      end
      if (cmd.add) begin
         fill_in = fill_ff + CNT_W'(1);
      end
      if (cmd.idx_inc) begin
         idx_in = idx_ff + CNT_W'(1);
      end
      if (cmd.move) begin
         fill_in    = last;
         removed_in = removed_ff + CNT_W'(1);
      end
      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.emit) begin
         rsp_valid_in   = 1'b1;
         status_in      = cmd.status;
         removed_out_in = ubag_pkg::COUNT_W'(removed_ff);
         entry_out_in   = ubag_pkg::COUNT_W'(fill_ff);
      end
   end

   assign wr_en   = cmd.add | cmd.move;
   assign wr_addr = cmd.add ? fill_ff[IDX_W-1:0] : idx_ff[IDX_W-1:0];
   assign wr_data = cmd.add ? value_ff : rd_data_ff;
   assign rd_addr = cmd.rd_last ? last[IDX_W-1:0] : idx_ff[IDX_W-1:0];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= entry_mem_ff[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff         <= idx_in;
      removed_ff     <= removed_in;
      value_ff       <= value_in;
      status_ff      <= status_in;
      removed_out_ff <= removed_out_in;
      entry_out_ff   <= entry_out_in;
   end

   assign stat.idx_end      = (idx_ff >= fill_ff);
   assign stat.match        = (rd_data_ff == value_ff);
   assign stat.full         = (fill_ff >= CNT_W'(CAPACITY));
   assign stat.removed_zero = (removed_ff == '0);
   assign stat.rsp_free     = ~rsp_valid_ff | rsp_ready;

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = status_ff;
   assign rsp_removed_count = removed_out_ff;
   assign rsp_entry_count   = entry_out_ff;

endmodule
`default_nettype wire

// ===== sv/ubag_ctrl.sv =====
// Bag controller: sequences add, scan, compare and swap-with-last steps.
`default_nettype none
module ubag_ctrl (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output      logic                           req_ready,
   input  wire logic [ubag_pkg::CMD_W-1:0]     req_command,
   input  wire ubag_pkg::dp_stat_type          stat,
   output      ubag_pkg::dp_cmd_type           cmd
);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_ADD  = 3'd1;
   localparam logic [2:0] S_SCAN = 3'd2;
   localparam logic [2:0] S_CMP  = 3'd3;
   localparam logic [2:0] S_MOVE = 3'd4;
   localparam logic [2:0] S_DONE = 3'd5;

   logic [2:0]                    state_ff, state_in;
   logic [ubag_pkg::CMD_W-1:0]    op_ff, op_in;
   logic [ubag_pkg::STATUS_W-1:0] status_ff, status_in;

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in  = state_ff;
      op_in     = op_ff;
      status_in = status_ff;
      cmd       = '0;
      cmd.status = status_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load  = 1'b1;
               op_in     = req_command;
               status_in = ubag_pkg::ST_DONE;
               case (req_command)
                  ubag_pkg::CMD_ADD:        state_in = S_ADD;
                  ubag_pkg::CMD_REMOVE_ONE: state_in = S_SCAN;
                  ubag_pkg::CMD_REMOVE_ALL: state_in = S_SCAN;
                  default:                  state_in = S_DONE;
               endcase
            end
         end
         S_ADD: begin
            if (stat.full) begin
               status_in = ubag_pkg::ST_FULL;
            end else begin
               cmd.add = 1'b1;
            end
            state_in = S_DONE;
         end
         S_SCAN: begin
            if (stat.idx_end) begin
               if (stat.removed_zero) begin
                  status_in = ubag_pkg::ST_NOT_FOUND;
               end
               state_in = S_DONE;
            end else begin
               state_in = S_CMP;
            end
         end
         S_CMP: begin
            if (stat.match) begin
               cmd.rd_last = 1'b1;
               state_in    = S_MOVE;
            end else begin
               cmd.idx_inc = 1'b1;
               state_in    = S_SCAN;
            end
         end
         S_MOVE: begin
            cmd.move = 1'b1;
            state_in = (op_ff == ubag_pkg::CMD_REMOVE_ONE) ? S_DONE : S_SCAN;
         end
         S_DONE: begin
            if (stat.rsp_free) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff     <= op_in;
      status_ff <= status_in;
   end

endmodule
`default_nettype wire

// ===== verif/bag_result_checker.sv =====
// Watches the bag's request and response channels, predicts each response and compares it.
`timescale 1ns / 100ps
module bag_result_checker #(
   parameter int CAPACITY = ubag_pkg::CAPACITY_DEFAULT
) (
   input wire logic clock,
   input wire logic reset,
   ubag_req_if      req,
   ubag_rsp_if      rsp,
   output int       failures,
   output int       pending,
   output int       checked
);

   typedef struct packed {
      logic [ubag_pkg::STATUS_W-1:0] status;
      logic [ubag_pkg::COUNT_W-1:0]  removed;
      logic [ubag_pkg::COUNT_W-1:0]  count;
   } bag_result_type;

   logic [ubag_pkg::ITEM_W-1:0] contents [CAPACITY];
   int                          held;
   int                          mismatches;
   int                          seen;
   bag_result_type              awaited_q [$];

   // swap-with-last removal of the lowest-indexed match
   function automatic bit take_first(logic [ubag_pkg::ITEM_W-1:0] v);
      for (int i = 0; i < held; i++) begin
         if (contents[i] == v) begin
            contents[i] = contents[held-1];
            held--;
            return 1'b1;
         end
      end
      return 1'b0;
   endfunction

   function automatic bag_result_type bag_apply(logic [ubag_pkg::CMD_W-1:0] cmd,
                                                logic [ubag_pkg::ITEM_W-1:0] v);
      bag_result_type r;
      r.status  = ubag_pkg::ST_DONE;
      r.removed = '0;
      case (cmd)
         ubag_pkg::CMD_ADD: begin
            if (held >= CAPACITY) begin
               r.status = ubag_pkg::ST_FULL;
            end else begin
               contents[held] = v;
               held++;
            end
         end
         ubag_pkg::CMD_REMOVE_ONE: begin
            if (take_first(v)) r.removed = ubag_pkg::COUNT_W'(1);
            else r.status = ubag_pkg::ST_NOT_FOUND;
         end
         ubag_pkg::CMD_REMOVE_ALL: begin
            while (take_first(v)) r.removed = r.removed + 1'b1;
            if (r.removed == '0) r.status = ubag_pkg::ST_NOT_FOUND;
         end
         default: ;
      endcase
      r.count = ubag_pkg::COUNT_W'(held);
      return r;
   endfunction

   task automatic note_failure(string what);
      mismatches++;
      if (mismatches <= 10) $display("[%0t] mismatch: %s", $realtime, what);
   endtask

   always @(posedge clock) begin
      bag_result_type want;
      if (reset) begin
         awaited_q.delete();
         held       = 0;
         mismatches = 0;
         seen       = 0;
      end else begin
         if (rsp.valid && rsp.ready) begin
            seen++;
            if (awaited_q.size() == 0) begin
               note_failure($sformatf("unexpected item status %0d removed %0d count %0d",
                  rsp.status, rsp.removed_count, rsp.entry_count));
            end else begin
               want = awaited_q.pop_front();
               if (rsp.status !== want.status || rsp.removed_count !== want.removed ||
                   rsp.entry_count !== want.count)
                  note_failure($sformatf(
                     "expected status %0d removed %0d count %0d, got %0d %0d %0d",
                     want.status, want.removed, want.count,
                     rsp.status, rsp.removed_count, rsp.entry_count));
            end
         end
         if (req.valid && req.ready)
            awaited_q.push_back(bag_apply(req.command, req.item_value));
      end
      failures <= mismatches;
      checked  <= seen;
      pending  <= awaited_q.size();
   end

endmodule

// ===== verif/tb_unordered_bag_swap_remove.sv =====
// Testbench top for the unordered bag: clock, reset, request stimulus, response stalls, verdict.
`timescale 1ns / 100ps
module tb_unordered_bag_swap_remove;

   localparam logic [ubag_pkg::CMD_W-1:0] CMD_SPARE   = 2'd3;
   localparam int                         CAPACITY    = ubag_pkg::CAPACITY_DEFAULT;
   localparam int                         SETTLE      = 4 * CAPACITY + 20;
   localparam int                         CYCLE_LIMIT = 3_000_000;

   logic clock;
   logic reset;
   bit   calm;
   int   failures;
   int   pending;
   int   checked;
   int   sent_by_cmd [4];

   ubag_req_if req_ch ();
   ubag_rsp_if rsp_ch ();

   unordered_bag_swap_remove dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   bag_result_checker #(.CAPACITY(CAPACITY)) checker_i (
      .clock    (clock),
      .reset    (reset),
      .req      (req_ch),
      .rsp      (rsp_ch),
      .failures (failures),
      .pending  (pending),
      .checked  (checked)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      rsp_ch.ready <= !reset && (calm || $urandom_range(99) >= 36);
   end

   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("tb_unordered_bag_swap_remove NOT OK");
      $finish;
   end

   task automatic send_item(logic [ubag_pkg::CMD_W-1:0] cmd, logic [ubag_pkg::ITEM_W-1:0] val);
      while (!calm && $urandom_range(99) < 36) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid      <= 1'b1;
      req_ch.command    <= cmd;
      req_ch.item_value <= val;
      do @(posedge clock); while (!req_ch.ready);
      sent_by_cmd[cmd]++;
   endtask

   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
   endtask

   // mostly a few recurring values so removals find matches
   function automatic logic [ubag_pkg::ITEM_W-1:0] pick_value();
      case ($urandom_range(9))
         0: return '0;
         1: return '1;
         2: return 32'h8000_0000;
         3: return 32'h7fff_ffff;
         4: return 32'd1;
         5, 6: return ubag_pkg::ITEM_W'($urandom_range(15));
         default: return $urandom;
      endcase
   endfunction

   // mode 0 fills, 1 mixes, 2 drains
   function automatic logic [ubag_pkg::CMD_W-1:0] pick_command(int mode);
      int r;
      r = $urandom_range(99);
      case (mode)
         0: return (r < 90) ? ubag_pkg::CMD_ADD : (r < 94) ? ubag_pkg::CMD_REMOVE_ONE :
                   (r < 98) ? ubag_pkg::CMD_REMOVE_ALL : CMD_SPARE;
         1: return (r < 50) ? ubag_pkg::CMD_ADD : (r < 75) ? ubag_pkg::CMD_REMOVE_ONE :
                   (r < 95) ? ubag_pkg::CMD_REMOVE_ALL : CMD_SPARE;
         default: return (r < 22) ? ubag_pkg::CMD_ADD : (r < 60) ? ubag_pkg::CMD_REMOVE_ONE :
                         (r < 97) ? ubag_pkg::CMD_REMOVE_ALL : CMD_SPARE;
      endcase
   endfunction

   initial begin
      logic [ubag_pkg::ITEM_W-1:0] same;
      reset              = 1'b1;
      calm               = 1'b0;
      req_ch.valid      <= 1'b0;
      req_ch.command    <= ubag_pkg::CMD_ADD;
      req_ch.item_value <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed: empty bag, extremes, duplicates, swap-with-last, spare code
      send_item(ubag_pkg::CMD_REMOVE_ONE, '0);
      send_item(ubag_pkg::CMD_REMOVE_ALL, '0);
      send_item(CMD_SPARE, '0);
      send_item(ubag_pkg::CMD_ADD, 32'h8000_0000);
      send_item(ubag_pkg::CMD_ADD, 32'h7fff_ffff);
      send_item(ubag_pkg::CMD_ADD, '0);
      send_item(ubag_pkg::CMD_ADD, '1);
      send_item(ubag_pkg::CMD_ADD, '0);
      send_item(ubag_pkg::CMD_ADD, 32'h5555_5555);
      send_item(ubag_pkg::CMD_ADD, 32'haaaa_aaaa);
      send_item(ubag_pkg::CMD_ADD, '0);
      send_item(ubag_pkg::CMD_REMOVE_ONE, 32'h8000_0000);
      send_item(ubag_pkg::CMD_REMOVE_ONE, 32'haaaa_aaaa);
      send_item(ubag_pkg::CMD_REMOVE_ALL, '0);
      send_item(ubag_pkg::CMD_REMOVE_ALL, '0);
      send_item(ubag_pkg::CMD_REMOVE_ONE, 32'd1234);
      send_item(CMD_SPARE, '1);
      send_item(ubag_pkg::CMD_REMOVE_ONE, '1);
      send_item(ubag_pkg::CMD_REMOVE_ALL, 32'h7fff_ffff);
      send_item(ubag_pkg::CMD_REMOVE_ONE, 32'h5555_5555);
      send_item(ubag_pkg::CMD_ADD, 32'd7);
      send_item(ubag_pkg::CMD_ADD, 32'd7);
      send_item(ubag_pkg::CMD_REMOVE_ALL, 32'd7);
      wait_drained();

      // bag known empty: fill with one value past capacity, then clear it at once
      same = $urandom;
      repeat (CAPACITY + 1) send_item(ubag_pkg::CMD_ADD, same);
      send_item(ubag_pkg::CMD_REMOVE_ALL, same);

      for (int phase = 0; phase < 9; phase++) begin
         calm = (phase == 4);
         repeat (75) send_item(pick_command(phase % 3), pick_value());
         if (phase == 5) wait_drained();
      end
      calm = 1'b0;

      wait_drained();
      repeat (SETTLE) @(posedge clock);

      $display("Sent %0d items: %0d add, %0d remove-one, %0d remove-all, %0d spare code.",
         sent_by_cmd.sum(),
         sent_by_cmd[ubag_pkg::CMD_ADD], sent_by_cmd[ubag_pkg::CMD_REMOVE_ONE],
         sent_by_cmd[ubag_pkg::CMD_REMOVE_ALL], sent_by_cmd[CMD_SPARE]);
      $display("Checked %0d responses over empty, full and mixed bags with stalls both sides.",
         checked);
      if (failures == 0 && pending == 0) begin
         $display("tb_unordered_bag_swap_remove OK");
      end else begin
         $display("tb_unordered_bag_swap_remove NOT OK");
      end
      $finish;
   end

endmodule
